/* rtl/utx_pkg.sv */
// ----------------------------------------------------------------------------
// utx_pkg: shared types for the UTF-8 / UTF-16 transcoder
// Transaction payloads and the per-item result batch handed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package utx_pkg;

    // Most result units that one input transaction can produce
    localparam int MaxResults = 4;
    localparam int SlotW      = $clog2(MaxResults);
    localparam int CountW     = $clog2(MaxResults + 1);

    // Direction register codes
    localparam logic DirUtf8ToUtf16 = 1'b0;
    localparam logic DirUtf16ToUtf8 = 1'b1;

    typedef struct packed {
        logic [15:0] in_unit;
        logic        start_of_stream;
    } in_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        last;
        logic        error;
    } out_t;

    // All results caused by one input transaction, slot 0 first
    typedef struct packed {
        logic [CountW-1:0]           count;
        out_t [MaxResults-1:0]       slots;
    } batch_t;

endpackage

`default_nettype wire

/* rtl/utx_engine.sv */
// ----------------------------------------------------------------------------
// utx_engine: conversion state and single-pass transcode logic
// Holds the stream state and forms the full result batch of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            accept,
    input  wire utx_pkg::in_t    in_data,
    output utx_pkg::batch_t      batch
);

    logic        direction_reg;
    logic [20:0] code_accum_reg,       code_accum_next;
    logic [1:0]  pending_count_reg,    pending_count_next;
    logic [10:0] high_unit_offset_reg, high_unit_offset_next;
    logic        have_high_unit_reg,   have_high_unit_next;
    logic        halted_reg,           halted_next;

    // Build the error batch: one unit, zero payload, last and error set
    function automatic utx_pkg::batch_t fail_batch();
        utx_pkg::batch_t b;
        b = '0;
        b.count             = utx_pkg::CountW'(1);
        b.slots[0].last     = 1'b1;
        b.slots[0].error    = 1'b1;
        return b;
    endfunction

    // Encode a code point as UTF-16 units; surrogate values fail
    function automatic utx_pkg::batch_t emit_utf16(input logic [20:0] cp);
        utx_pkg::batch_t b;
        logic [20:0]     rem;
        b   = '0;
        rem = cp - 21'h010000;
        if (cp < 21'h010000) begin
            if (cp >= 21'h00D800 && cp < 21'h00E000) begin
                b = fail_batch();
            end else begin
                b.count             = utx_pkg::CountW'(1);
                b.slots[0].out_unit = cp[15:0];
                b.slots[0].last     = 1'b1;
            end
        end else begin
            b.count             = utx_pkg::CountW'(2);
            b.slots[0].out_unit = 16'hD800 + {5'd0, rem[20:10]};
            b.slots[1].out_unit = {6'b110111, rem[9:0]};
            b.slots[1].last     = 1'b1;
        end
        return b;
    endfunction

    // Encode a 22-bit value as 1 to 4 UTF-8 bytes
    function automatic utx_pkg::batch_t emit_utf8(input logic [21:0] cp);
        utx_pkg::batch_t b;
        b = '0;
        if (cp < 22'd128) begin
            b.count             = utx_pkg::CountW'(1);
            b.slots[0].out_unit = {9'd0, cp[6:0]};
            b.slots[0].last     = 1'b1;
        end else if (cp < 22'd2048) begin
            b.count             = utx_pkg::CountW'(2);
            b.slots[0].out_unit = {8'd0, 3'b110, cp[10:6]};
            b.slots[1].out_unit = {8'd0, 2'b10, cp[5:0]};
            b.slots[1].last     = 1'b1;
        end else if (cp < 22'd65536) begin
            b.count             = utx_pkg::CountW'(3);
            b.slots[0].out_unit = {8'd0, 4'b1110, cp[15:12]};
            b.slots[1].out_unit = {8'd0, 2'b10, cp[11:6]};
            b.slots[2].out_unit = {8'd0, 2'b10, cp[5:0]};
            b.slots[2].last     = 1'b1;
        end else begin
            b.count             = utx_pkg::CountW'(4);
            b.slots[0].out_unit = {8'd0, 5'b11110, cp[20:18]};
            b.slots[1].out_unit = {8'd0, 2'b10, cp[17:12]};
            b.slots[2].out_unit = {8'd0, 2'b10, cp[11:6]};
            b.slots[3].out_unit = {8'd0, 2'b10, cp[5:0]};
            b.slots[3].last     = 1'b1;
        end
        return b;
    endfunction

    // Transcode one transaction against the current stream state
    always_comb begin
        logic [7:0]  byte_in;
        logic [20:0] acc_shift;
        logic [21:0] pair_sum;
        byte_in   = in_data.in_unit[7:0];
        acc_shift = {code_accum_reg[14:0], byte_in[5:0]};
        pair_sum  = {1'b0, high_unit_offset_reg, 10'd0} + {6'd0, in_data.in_unit}
                    + 22'd9216;

        code_accum_next       = code_accum_reg;
        pending_count_next    = pending_count_reg;
        high_unit_offset_next = high_unit_offset_reg;
        have_high_unit_next   = have_high_unit_reg;
        halted_next           = halted_reg;
        batch                 = '0;

        // Drop any pending sequence and leave the halted state
        if (in_data.start_of_stream) begin
            code_accum_next       = '0;
            pending_count_next    = '0;
            high_unit_offset_next = '0;
            have_high_unit_next   = 1'b0;
            halted_next           = 1'b0;
            pair_sum              = {6'd0, in_data.in_unit} + 22'd9216;
        end

        if (!halted_next) begin
            if (direction_reg == utx_pkg::DirUtf8ToUtf16) begin
                if (pending_count_next == 2'd0) begin
                    priority if (byte_in < 8'h80) begin
                        batch = emit_utf16({13'd0, byte_in});
                    end else if (byte_in >= 8'hF0) begin
                        code_accum_next    = {18'd0, byte_in[2:0]};
                        pending_count_next = 2'd3;
                    end else if (byte_in >= 8'hE0) begin
                        code_accum_next    = {17'd0, byte_in[3:0]};
                        pending_count_next = 2'd2;
                    end else if (byte_in >= 8'hC0) begin
                        code_accum_next    = {16'd0, byte_in[4:0]};
                        pending_count_next = 2'd1;
                    end else begin
                        batch = fail_batch();
                    end
                end else if (byte_in[7:6] != 2'b10) begin
                    batch = fail_batch();
                end else begin
                    // Shift in six payload bits per continuation byte
                    code_accum_next    = acc_shift;
                    pending_count_next = pending_count_next - 2'd1;
                    if (pending_count_next == 2'd0) begin
                        batch = emit_utf16(acc_shift);
                    end
                end
                // Halt and clear the sequence on any error
                if (batch.slots[0].error) begin
                    halted_next        = 1'b1;
                    pending_count_next = '0;
                    code_accum_next    = '0;
                end
            end else begin
                if (!have_high_unit_next) begin
                    if (in_data.in_unit >= 16'hD800 && in_data.in_unit < 16'hE000) begin
                        high_unit_offset_next = in_data.in_unit[10:0] - 11'h000;
                        have_high_unit_next   = 1'b1;
                    end else begin
                        batch = emit_utf8({6'd0, in_data.in_unit});
                    end
                end else begin
                    have_high_unit_next = 1'b0;
                    batch               = emit_utf8(pair_sum);
                end
            end
        end
    end

    // Commit the state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg        <= utx_pkg::DirUtf8ToUtf16;
            code_accum_reg       <= '0;
            pending_count_reg    <= '0;
            high_unit_offset_reg <= '0;
            have_high_unit_reg   <= 1'b0;
            halted_reg           <= 1'b0;
        end else begin
            if (cfg_we) begin
                direction_reg <= cfg_wdata;
            end
            if (accept) begin
                code_accum_reg       <= code_accum_next;
                pending_count_reg    <= pending_count_next;
                high_unit_offset_reg <= high_unit_offset_next;
                have_high_unit_reg   <= have_high_unit_next;
                halted_reg           <= halted_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/utx_out_buffer.sv */
// ----------------------------------------------------------------------------
// utx_out_buffer: result register and unit serializer
// Holds one transaction's result batch and hands it out one unit per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module utx_out_buffer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire utx_pkg::batch_t batch,
    output logic                 load_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output utx_pkg::out_t        m_data
);

    utx_pkg::out_t [utx_pkg::MaxResults-1:0] slots_reg;
    logic [utx_pkg::CountW-1:0]              remain_reg, remain_next;
    logic [utx_pkg::SlotW-1:0]               pos_reg,    pos_next;
    logic                                    pop;

    assign m_valid    = (remain_reg != '0);
    assign m_data     = slots_reg[pos_reg];
    assign pop        = m_valid && m_ready;
    // Take a new batch when empty or once the last held unit leaves this cycle
    assign load_ready = (remain_reg == '0) ||
                        (remain_reg == utx_pkg::CountW'(1) && m_ready);

    // Advance through the held units or load a fresh batch
    always_comb begin
        remain_next = remain_reg;
        pos_next    = pos_reg;
        if (load) begin
            remain_next = batch.count;
            pos_next    = '0;
        end else if (pop) begin
            remain_next = remain_reg - utx_pkg::CountW'(1);
            pos_next    = pos_reg + utx_pkg::SlotW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
            pos_reg    <= '0;
        end else begin
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
        end
    end

    // Hold the payload of the current batch
    always_ff @(posedge aclk) begin
        if (load) begin
            slots_reg <= batch.slots;
        end
    end

endmodule

`default_nettype wire

/* rtl/utf8_utf16_transcoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder_unit: streaming UTF-8 / UTF-16 transcoder
// Direction set by a one-bit register; one code unit in, zero to four out.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Payload
//  s_        s_valid  s_ready  s_data      in_unit, start_of_stream
//  m_        m_valid  m_ready  m_data      out_unit, last, error
//  cfg_      cfg_we   cfg_wdata            direction (no handshake)
//
//  An input transaction is transcoded in the cycle it is accepted and its
//  results sit in the result register from the next cycle on.
//  Rate: one result unit per cycle while m_ready is high; items that yield
//  no unit, and single-unit items while m_ready is high, flow at one per cycle.
//  The result serializer holds the flow: s_ready falls while it holds more
//  than one unit, or one unit that m_ready does not take in that cycle.
//  Reset (aresetn low, synchronous) clears all state but the held result payload.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_utf16_transcoder_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic            cfg_wdata,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire utx_pkg::in_t    s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output utx_pkg::out_t        m_data
);

    utx_pkg::batch_t batch;
    logic            accept;

    // Accept a transaction when the serializer can take its batch
    assign accept = s_valid && s_ready;

    utx_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_data   (s_data),
        .batch     (batch)
    );

    utx_out_buffer u_out_buffer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .batch      (batch),
        .load_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_utf16_transcoder_unit
// Drives code units through the input channel in both directions, keeps a
// local model of the transcoder state to predict each result unit, and checks
// every result transaction against the oldest prediction. Directed cases come
// first, then backpressure and long random streams of well-formed and broken
// sequences.
// ----------------------------------------------------------------------------
module testbench;

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    utx_pkg::in_t  s_data    = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    utx_pkg::out_t m_data;

    int tx_idle_pct = 8;
    int rx_idle_pct = 8;
    int rx_holdoff  = 0;
    int fail_count  = 0;
    int units_sent  = 0;

    // Result units predicted but not yet seen, oldest first
    utx_pkg::out_t expected_units[$];
    utx_pkg::out_t oldest_unit;

    // Local copy of the transcoder state and its direction register
    logic        dir_q     = utx_pkg::DirUtf8ToUtf16;
    logic [20:0] acc_cp    = '0;
    logic [1:0]  cont_left = '0;
    logic [10:0] hi_offset = '0;
    logic        hi_valid  = 1'b0;
    logic        is_halted = 1'b0;

    utf8_utf16_transcoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void push_unit(input logic [15:0] code_unit, input logic is_last);
        expected_units.push_back(utx_pkg::out_t'{code_unit, is_last, 1'b0});
    endfunction

    // Emit the error unit, drop any pending UTF-8 sequence and halt
    function automatic void flag_error();
        expected_units.push_back(utx_pkg::out_t'{16'h0000, 1'b1, 1'b1});
        is_halted = 1'b1;
        cont_left = '0;
        acc_cp    = '0;
    endfunction

    function automatic void utf16_out(input logic [20:0] cp);
        logic [20:0] rem;
        if (cp < 21'h10000) begin
            if (cp >= 21'h0D800 && cp < 21'h0E000) flag_error();
            else push_unit(cp[15:0], 1'b1);
        end else begin
            // Code points past 0x10FFFF still split; the high unit lands at 0xDC00 or above
            rem = cp - 21'h10000;
            push_unit(16'hD800 + {5'b0, rem[20:10]}, 1'b0);
            push_unit(16'hDC00 + {6'b0, rem[9:0]}, 1'b1);
        end
    endfunction

    function automatic void utf8_out(input logic [21:0] cp);
        if (cp < 22'd128) begin
            push_unit({9'b0, cp[6:0]}, 1'b1);
        end else if (cp < 22'd2048) begin
            push_unit({8'b0, 3'b110, cp[10:6]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[5:0]}, 1'b1);
        end else if (cp < 22'd65536) begin
            push_unit({8'b0, 4'b1110, cp[15:12]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[11:6]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[5:0]}, 1'b1);
        end else begin
            // Four-byte form keeps only the low 21 bits
            push_unit({8'b0, 5'b11110, cp[20:18]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[17:12]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[11:6]}, 1'b0);
            push_unit({8'b0, 2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    function automatic void transcode_predict(input utx_pkg::in_t item);
        logic [7:0]  b;
        logic [31:0] pair_sum;
        if (item.start_of_stream) begin
            acc_cp    = '0;
            cont_left = '0;
            hi_offset = '0;
            hi_valid  = 1'b0;
            is_halted = 1'b0;
        end
        if (is_halted) return;
        if (dir_q == utx_pkg::DirUtf8ToUtf16) begin
            b = item.in_unit[7:0];
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    utf16_out({13'b0, b});
                end else if (b >= 8'hF0) begin
                    acc_cp    = {18'b0, b[2:0]};
                    cont_left = 2'd3;
                end else if (b >= 8'hE0) begin
                    acc_cp    = {17'b0, b[3:0]};
                    cont_left = 2'd2;
                end else if (b >= 8'hC0) begin
                    acc_cp    = {16'b0, b[4:0]};
                    cont_left = 2'd1;
                end else begin
                    flag_error();
                end
            end else if (b[7:6] != 2'b10) begin
                flag_error();
            end else begin
                acc_cp    = {acc_cp[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) utf16_out(acc_cp);
            end
        end else if (!hi_valid) begin
            if (item.in_unit >= 16'hD800 && item.in_unit < 16'hE000) begin
                hi_offset = item.in_unit[10:0];
                hi_valid  = 1'b1;
            end else begin
                utf8_out({6'b0, item.in_unit});
            end
        end else begin
            // Partner unit is taken as is; the sum wraps at 22 bits
            hi_valid = 1'b0;
            pair_sum = ({21'b0, hi_offset} << 10) + {16'b0, item.in_unit}
                       - 32'h0000DC00 + 32'h00010000;
            utf8_out(pair_sum[21:0]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------
    task automatic send_unit(input logic [15:0] code_unit, input logic sos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= utx_pkg::in_t'{code_unit, sos};
        do @(posedge aclk); while (!s_ready);
        transcode_predict(s_data);
        units_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted unit has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_units.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_direction(input logic dir);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= dir;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        dir_q = dir;
    endtask

    // ------------------------------------------------------------------
    // Result channel: ready with random idling and an optional hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_holdoff > 0) begin
            m_ready <= 1'b0;
            rx_holdoff = rx_holdoff - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                $error("unexpected result: out_unit %h last %b error %b",
                       m_data.out_unit, m_data.last, m_data.error);
                fail_count++;
            end else begin
                oldest_unit = expected_units.pop_front();
                if (m_data.out_unit !== oldest_unit.out_unit) begin
                    $error("out_unit: expected %h, got %h",
                           oldest_unit.out_unit, m_data.out_unit);
                    fail_count++;
                end
                if (m_data.last !== oldest_unit.last) begin
                    $error("last: expected %b, got %b", oldest_unit.last, m_data.last);
                    fail_count++;
                end
                if (m_data.error !== oldest_unit.error) begin
                    $error("error: expected %b, got %b", oldest_unit.error, m_data.error);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stream generators
    // ------------------------------------------------------------------
    // Mostly restart the stream once it has halted
    function automatic logic pick_sos();
        if (is_halted) return ($urandom_range(0, 3) != 0);
        return ($urandom_range(0, 39) == 0);
    endfunction

    task automatic send_random_utf8();
        int         kind;
        int         len;
        logic [7:0] lead;
        logic [7:0] body;
        logic [7:0] upper;
        kind  = $urandom_range(0, 99);
        upper = 8'($urandom_range(0, 255));
        if (kind < 10) begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 9) == 0);
            return;
        end
        len = $urandom_range(1, 4);
        case (len)
            1: begin
                lead = 8'($urandom_range(0, 8'h7F));
            end
            2: begin
                lead = 8'hC0 + 8'($urandom_range(0, 31));
            end
            3: begin
                lead = 8'hE0 + 8'($urandom_range(0, 15));
            end
            default: begin
                lead = 8'hF0 + 8'($urandom_range(0, 15));
            end
        endcase
        send_unit({upper, lead}, pick_sos());
        repeat (len - 1) begin
            if ($urandom_range(0, 19) == 0) body = 8'($urandom_range(0, 255));
            else body = 8'h80 + 8'($urandom_range(0, 63));
            upper = 8'($urandom_range(0, 255));
            send_unit({upper, body}, 1'b0);
        end
    endtask

    task automatic send_random_utf16();
        int          kind;
        logic [15:0] code_unit;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            send_unit(16'($urandom_range(0, 127)), pick_sos());
        end else if (kind < 30) begin
            send_unit(16'($urandom_range(128, 2047)), pick_sos());
        end else if (kind < 50) begin
            // Any non-surrogate unit
            code_unit = 16'($urandom_range(0, 16'hF7FF));
            if (code_unit >= 16'hD800) code_unit = code_unit + 16'h0800;
            send_unit(code_unit, pick_sos());
        end else if (kind < 85) begin
            send_unit(16'hD800 + 16'($urandom_range(0, 16'h03FF)), pick_sos());
            send_unit(16'hDC00 + 16'($urandom_range(0, 16'h03FF)), 1'b0);
        end else begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic run_random_phase(input logic dir, input int n_units, input int idle_pct);
        int target;
        write_direction(dir);
        tx_idle_pct = idle_pct;
        rx_idle_pct = idle_pct;
        target = units_sent + n_units;
        while (units_sent < target) begin
            if (dir == utx_pkg::DirUtf8ToUtf16) send_random_utf8();
            else send_random_utf16();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_utf8_decode();
        write_direction(utx_pkg::DirUtf8ToUtf16);
        send_unit(16'h0000, 1'b1);
        // Upper bits of the unit are ignored
        send_unit(16'hFF7F, 1'b0);
        send_unit(16'h00C3, 1'b0);
        send_unit(16'h00A9, 1'b0);
        // Code point past 0x10FFFF still yields a pair
        send_unit(16'h00FF, 1'b0);
        send_unit(16'h00BF, 1'b0);
        send_unit(16'h00BF, 1'b0);
        send_unit(16'h00BF, 1'b0);
        // Surrogate code point, then a unit dropped while halted
        send_unit(16'h00ED, 1'b0);
        send_unit(16'h00A0, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h0041, 1'b0);
        // Stray continuation as lead, then a bad continuation
        send_unit(16'h0080, 1'b1);
        send_unit(16'h00C3, 1'b1);
        send_unit(16'h0041, 1'b0);
    endtask

    task automatic test_utf16_encode();
        write_direction(utx_pkg::DirUtf16ToUtf8);
        send_unit(16'h0041, 1'b1);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b0);
        // Unchecked partner: the sum passes bit 21, which the four-byte form loses
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
    endtask

    // Each direction keeps its pending sequence across a switch
    task automatic test_direction_switch();
        write_direction(utx_pkg::DirUtf8ToUtf16);
        send_unit(16'h00E2, 1'b1);
        send_unit(16'h0082, 1'b0);
        write_direction(utx_pkg::DirUtf16ToUtf8);
        send_unit(16'hD83D, 1'b0);
        write_direction(utx_pkg::DirUtf8ToUtf16);
        send_unit(16'h00AC, 1'b0);
        write_direction(utx_pkg::DirUtf16ToUtf8);
        send_unit(16'hDE00, 1'b0);
        // Halt raised in one direction holds in the other
        write_direction(utx_pkg::DirUtf8ToUtf16);
        send_unit(16'h0080, 1'b0);
        write_direction(utx_pkg::DirUtf16ToUtf8);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b1);
    endtask

    // Stall the result side long enough to fill the block and block input
    task automatic test_backpressure();
        write_direction(utx_pkg::DirUtf16ToUtf8);
        tx_idle_pct = 0;
        rx_holdoff  = 200;
        repeat (40) send_random_utf16();
        drain_results();
        tx_idle_pct = 8;
    endtask

    task automatic test_random_stream();
        run_random_phase(utx_pkg::DirUtf8ToUtf16, 100, 8);
        // Stretch without idling, split by a full sender pause
        run_random_phase(utx_pkg::DirUtf16ToUtf8, 50, 0);
        drain_results();
        run_random_phase(utx_pkg::DirUtf16ToUtf8, 50, 0);
        run_random_phase(utx_pkg::DirUtf8ToUtf16, 60, 8);
        run_random_phase(utx_pkg::DirUtf16ToUtf8, 60, 8);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_utf8_decode();
        test_utf16_encode();
        test_direction_switch();
        test_backpressure();
        test_random_stream();
        drain_results();
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && expected_units.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #(4 * 400_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
